/* sv/hcrc_pkg.sv */
// ----------------------------------------------------------------------------
// hcrc_pkg
// Shared types and constants of the hop-count route cache: item structs,
// status codes, configuration register indexes and the control/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package hcrc_pkg;

  localparam logic KIND_LEARN  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [3:0] ST_OWN       = 4'd0;
  localparam logic [3:0] ST_NEW       = 4'd1;
  localparam logic [3:0] ST_REPLACED  = 4'd2;
  localparam logic [3:0] ST_REFRESHED = 4'd3;
  localparam logic [3:0] ST_UNCHANGED = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_NOROUTE   = 4'd6;
  localparam logic [3:0] ST_STALE     = 4'd7;
  localparam logic [3:0] ST_FOUND     = 4'd8;

  localparam logic CFG_OWN_IP   = 1'b0;
  localparam logic CFG_STALE_MS = 1'b1;

  localparam logic [31:0] OWN_IP_RESET   = 32'd0;
  localparam logic [31:0] STALE_MS_RESET = 32'd5000;

  typedef struct packed {
    logic        kind;
    logic [31:0] ip;
    logic [15:0] hop_cnt;
    logic [7:0]  if_index;
    logic [47:0] next_mac;
    logic        forced;
    logic        suppress_advert;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        advertise;
    logic [7:0]  out_if_index;
    logic [47:0] out_mac;
    logic [15:0] out_hop_cnt;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [7:0]  if_index;
    logic [47:0] mac;
    logic [15:0] hops;
    logic [31:0] stamp;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic scan_clr;  // restart the scan pointer
    logic rd_en;     // read the entry under the scan pointer and advance
    logic decide;    // resolve the item, update the table, load the result
    logic hit;       // the last read entry matched the item's address
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ip_match;    // registered entry holds the item's address
    logic all_issued;  // every filled entry has been read
    logic out_busy;    // result register holds a result that is not taken
  } stat_t;

endpackage

/* sv/hop_count_route_cache_top.sv */
// ----------------------------------------------------------------------------
// hop_count_route_cache_top
// Route cache for on-demand routing with hop-count based route selection.
// ----------------------------------------------------------------------------
// Each item (learn or lookup) is accepted only while no other item is being
// worked on. The table sits in a single memory read one entry per cycle, and
// the scan covers the routes held (at most ROUTE_ENTRIES) and stops early on
// a match. The result register lets the next item be taken while a result
// waits. Routes are never aged out of the table; a full table drops new
// routes with a full status. Configuration writes are taken in any cycle,
// one per transfer.
module hop_count_route_cache_top #(
  parameter int ROUTE_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcrc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);

  hcrc_pkg::cmd_t  cmd;
  hcrc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  hcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hcrc_dp #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* sv/hcrc_dp.sv */
// ----------------------------------------------------------------------------
// hcrc_dp
// Datapath of the route cache: configuration registers, item register,
// entry memory with registered read port, fill count, scan pointer,
// decision logic and the result register.
// ----------------------------------------------------------------------------
module hcrc_dp #(
  parameter int ROUTE_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  hcrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcrc_pkg::out_item_t out_data,
  input  hcrc_pkg::cmd_t      cmd,
  output hcrc_pkg::stat_t     stat
);

  localparam int CW = $clog2(ROUTE_ENTRIES + 1);
  localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ROUTE_ENTRIES);

  logic [31:0]         own_ip_r;
  logic [31:0]         stale_ms_r;
  hcrc_pkg::in_item_t  item_r;
  hcrc_pkg::entry_t    mem [ROUTE_ENTRIES];
  hcrc_pkg::entry_t    rd_q_r;
  logic [AW-1:0]       rd_addr_r;
  logic [CW-1:0]       scan_idx_r;
  logic [CW-1:0]       fill_cnt_r;
  logic                out_valid_r;
  hcrc_pkg::out_item_t out_r;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  hcrc_pkg::entry_t    wr_data;
  logic                fill_inc;
  hcrc_pkg::out_item_t res;
  logic [32:0]         expiry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r   <= hcrc_pkg::OWN_IP_RESET;
      stale_ms_r <= hcrc_pkg::STALE_MS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hcrc_pkg::CFG_OWN_IP:   own_ip_r   <= cfg_data;
        hcrc_pkg::CFG_STALE_MS: stale_ms_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // Entries are only ever added at the lowest free slot and never removed,
  // so the valid entries are exactly those below the fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      fill_cnt_r <= '0;
    end else begin
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
      end else if (cmd.rd_en) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (fill_inc) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q_r    <= mem[scan_idx_r[AW-1:0]];
      rd_addr_r <= scan_idx_r[AW-1:0];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign expiry = {1'b0, rd_q_r.stamp} + {1'b0, stale_ms_r};

  always_comb begin
    res      = '0;
    wr_en    = 1'b0;
    wr_addr  = rd_addr_r;
    fill_inc = 1'b0;
    wr_data.ip       = item_r.ip;
    wr_data.if_index = item_r.if_index;
    wr_data.mac      = item_r.next_mac;
    wr_data.hops     = item_r.hop_cnt;
    wr_data.stamp    = item_r.now_ms;
    if (item_r.kind == hcrc_pkg::KIND_LEARN) begin
      priority if (item_r.ip == own_ip_r) begin
        res.status = hcrc_pkg::ST_OWN;
      end else if (!cmd.hit) begin
        if (fill_cnt_r == FULL_CNT) begin
          res.status = hcrc_pkg::ST_FULL;
        end else begin
          res.status    = hcrc_pkg::ST_NEW;
          res.advertise = !item_r.suppress_advert;
          wr_en         = cmd.decide;
          wr_addr       = fill_cnt_r[AW-1:0];
          fill_inc      = cmd.decide;
        end
      end else if (rd_q_r.hops > item_r.hop_cnt || item_r.forced) begin
        res.status    = hcrc_pkg::ST_REPLACED;
        res.advertise = !item_r.suppress_advert;
        wr_en         = cmd.decide;
      end else if (rd_q_r.hops == item_r.hop_cnt) begin
        // Only the stamp moves; interface and MAC stay as stored.
        res.status       = hcrc_pkg::ST_REFRESHED;
        wr_en            = cmd.decide;
        wr_data          = rd_q_r;
        wr_data.stamp    = item_r.now_ms;
      end else begin
        res.status = hcrc_pkg::ST_UNCHANGED;
      end
    end else begin
      priority if (!cmd.hit) begin
        res.status = hcrc_pkg::ST_NOROUTE;
      end else if (expiry < {1'b0, item_r.now_ms}) begin
        res.status = hcrc_pkg::ST_STALE;
      end else begin
        res.status        = hcrc_pkg::ST_FOUND;
        res.out_if_index  = rd_q_r.if_index;
        res.out_mac       = rd_q_r.mac;
        res.out_hop_cnt   = rd_q_r.hops;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign stat.ip_match   = (rd_q_r.ip == item_r.ip);
  assign stat.all_issued = (scan_idx_r == fill_cnt_r);
  assign stat.out_busy   = out_valid_r && !out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= FULL_CNT)
    else $error("fill count exceeds the table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> !(out_valid_r && !out_ready))
    else $error("result register loaded while a result is still pending");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r != $past(fill_cnt_r)) |-> $past(cmd.decide && !cmd.hit))
    else $error("fill count changed outside a new-route transfer");

endmodule

/* sv/hcrc_ctrl.sv */
// ----------------------------------------------------------------------------
// hcrc_ctrl
// Controller of the route cache: accepts an item, sweeps the filled entries
// one read per cycle, stops on the first address match and then has the
// datapath resolve the item into the result register.
// ----------------------------------------------------------------------------
module hcrc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hcrc_pkg::stat_t stat,
  output hcrc_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   cmp_vld_r, cmp_vld_nxt;
  logic   hit_r, hit_nxt;
  logic   hit_now;

  // A compare is valid in the cycle after a read was issued.
  assign hit_now = cmp_vld_r && stat.ip_match;

  always_comb begin
    state_nxt   = state_r;
    cmp_vld_nxt = 1'b0;
    hit_nxt     = hit_r;
    cmd         = '0;
    cmd.hit     = hit_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture  = in_valid;
        cmd.scan_clr = in_valid;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en   = !hit_now && !stat.all_issued;
        cmp_vld_nxt = cmd.rd_en;
        priority if (hit_now) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DECIDE;
        end else if (!cmp_vld_r && stat.all_issued) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DECIDE: begin
        cmd.decide = !stat.out_busy;
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      hit_r     <= hit_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !stat.all_issued)
    else $error("entry read issued past the fill count");

  a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> in_ready)
    else $error("item captured outside an input transfer");

  a_no_compare_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> !cmp_vld_r)
    else $error("entry compare still pending while the item is resolved");

endmodule
